// ===== rtl/core/histogram_overlay_pixel_render_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the histogram overlay pixel render unit
// Shared property wrappers, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef HISTOGRAM_OVERLAY_PIXEL_RENDER_UNIT_ASSERT_SVH
`define HISTOGRAM_OVERLAY_PIXEL_RENDER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define HOPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hopr assertion failed");

// Consequent must hold in the cycle after the antecedent
`define HOPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hopr assertion failed");

`endif

// ===== rtl/core/hopr_pkg.sv =====
// ---------------------------------------------------------------------------
// hopr_pkg
// Widths, codes, pixel levels and types of the histogram overlay renderer.
// ---------------------------------------------------------------------------
package hopr_pkg;

    // Field widths
    localparam int CNT_W = 32;
    localparam int BIN_W = 8;
    localparam int ROW_W = 7;
    localparam int PIX_W = 8;

    // Default geometry
    localparam int BIN_COUNT_DEF = 256;
    localparam int ROW_COUNT_DEF = 128;

    // Pixel levels
    localparam logic [PIX_W-1:0] PIX_NONE = 8'h00;
    localparam logic [PIX_W-1:0] PIX_BAR  = 8'h50;
    localparam logic [PIX_W-1:0] PIX_DIM  = 8'h80;
    localparam logic [PIX_W-1:0] PIX_TOP  = 8'hFF;

    // Command codes
    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } t_state;

    // Per-channel bar position relative to the current row
    typedef struct packed {
        logic pos;   // bar has non-zero height
        logic gt;    // row lies below the bar top
        logic eq;    // row is the bar top
    } t_bar;

endpackage

// ===== rtl/core/hopr_ram.sv =====
// ---------------------------------------------------------------------------
// hopr_ram
// Generic single-port RAM, one write or read a cycle, registered read data.
// ---------------------------------------------------------------------------
module hopr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hopr_div.sv =====
// ---------------------------------------------------------------------------
// hopr_div
// Restoring divider, one quotient bit a cycle. Only the low QW quotient bits
// are formed; a quotient of 2**QW or more is flagged as saturated.
// ---------------------------------------------------------------------------
module hopr_div
    import hopr_pkg::*;
#(
    parameter int DW = CNT_W,
    parameter int QW = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW+QW-1:0] i_dividend,
    input  logic [DW-1:0]    i_divisor,
    output logic [QW-1:0]    o_quot,
    output logic             o_sat,
    output logic             o_done
);

    localparam int XW = DW + QW;
    localparam int KW = $clog2(QW + 1);

    logic          r_run;
    logic [KW-1:0] r_cnt;
    logic [XW-1:0] r_rem;
    logic [XW-1:0] r_div;
    logic [QW-1:0] r_quot;
    logic          r_sat;
    logic          w_fit;

    assign w_fit = (r_rem >= r_div);

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= KW'(QW);
        end else if (r_run) begin
            r_cnt <= r_cnt - KW'(1);
            if (r_cnt == KW'(1)) begin
                r_run <= 1'b0;
            end
        end
    end

    // Datapath: saturation check on load, then shift-subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat  <= (i_dividend >= (XW'(i_divisor) << QW));
            r_rem  <= i_dividend;
            r_div  <= XW'(i_divisor) << (QW - 1);
            r_quot <= '0;
        end else if (r_run) begin
            if (w_fit) begin
                r_rem <= r_rem - r_div;
            end
            r_div  <= r_div >> 1;
            r_quot <= (r_quot << 1) | QW'(w_fit);
        end
    end

    assign o_quot = r_quot;
    assign o_sat  = r_sat;
    assign o_done = r_run && (r_cnt == KW'(1));

endmodule

// ===== rtl/core/histogram_overlay_pixel_render_unit.sv =====
// ---------------------------------------------------------------------------
// histogram_overlay_pixel_render_unit
// Histogram bin store with running peaks and overlay pixel rendering.
// ---------------------------------------------------------------------------
// Clear and write beats leave the sequencer idle; busy stays low afterwards.
// A read beat gives its pixel after RAM read, scale, three parallel
// bit-serial divides and the registered pixel composition.
// One read in flight at a time: busy blocks new commands until it is done.
// Reset (synchronous, active low) clears both peaks and the sequencer; bin
// store contents are left as they are.
module histogram_overlay_pixel_render_unit
    import hopr_pkg::*;
#(
    parameter int BIN_COUNT = BIN_COUNT_DEF,
    parameter int ROW_COUNT = ROW_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_action,
    input  logic [BIN_W-1:0] i_bin,
    input  logic [ROW_W-1:0] i_row,
    input  logic [CNT_W-1:0] i_red_count,
    input  logic [CNT_W-1:0] i_green_count,
    input  logic [CNT_W-1:0] i_blue_count,
    output logic             o_strobe,
    output logic [PIX_W-1:0] o_pixel_red,
    output logic [PIX_W-1:0] o_pixel_green,
    output logic [PIX_W-1:0] o_pixel_blue
);

    localparam int AW = $clog2(BIN_COUNT);
    localparam int RW = $clog2(ROW_COUNT);
    localparam int XW = CNT_W + RW;
    localparam int SW = ((RW > ROW_W) ? RW : ROW_W) + 2;
    localparam logic [SW-1:0] LAST_ROW = SW'(ROW_COUNT - 1);
    localparam logic [XW-1:0] LAST_X   = XW'(ROW_COUNT - 1);

    t_state r_state, n_state;
    t_action w_act;
    logic w_accept;

    // FSM outputs
    logic w_ram_we;
    logic w_div_start;

    // Peaks
    logic [CNT_W-1:0] r_run_peak;
    logic [CNT_W-1:0] r_last_peak;

    // Read context
    logic [ROW_W-1:0] r_row;
    logic             r_ok;
    logic [CNT_W-1:0] r_peak;
    logic [XW-1:0]    r_x_red, r_x_green, r_x_blue;

    // RAM
    logic [AW-1:0]      w_addr;
    logic [3*CNT_W-1:0] w_rdata;
    logic               w_bin_ok, w_bin_last, w_row_ok;

    // Divider results
    logic [RW-1:0] w_q_red, w_q_green, w_q_blue;
    logic          w_s_red, w_s_green, w_s_blue;
    logic          w_d_red, w_d_green, w_d_blue;
    logic          w_div_done;

    // Output
    logic             r_strobe;
    logic [PIX_W-1:0] r_pix_red, r_pix_green, r_pix_blue;
    logic [PIX_W-1:0] n_pix_red, n_pix_green, n_pix_blue;

    function automatic logic [CNT_W-1:0] max_cnt(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_bar bar_of(input logic [RW-1:0] q, input logic sat,
                                    input logic [ROW_W-1:0] row);
        t_bar b;
        logic [SW-1:0] sum;
        sum   = SW'(row) + SW'(q);
        b.pos = sat || (q != '0);
        b.gt  = sat || (sum > LAST_ROW);
        b.eq  = !sat && (sum == LAST_ROW);
        return b;
    endfunction

    assign w_act      = t_action'(i_action);
    assign w_accept   = start && !busy;
    assign w_addr     = AW'(i_bin);
    assign w_bin_ok   = (32'(i_bin) < 32'(BIN_COUNT));
    assign w_bin_last = (32'(i_bin) == 32'(BIN_COUNT - 1));
    assign w_row_ok   = (32'(i_row) < 32'(ROW_COUNT));
    assign w_div_done = w_d_red && w_d_green && w_d_blue;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_act == ACT_READ)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_LOAD;
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        busy        = 1'b1;
        w_ram_we    = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy     = 1'b0;
                w_ram_we = start && (w_act == ACT_WRITE) && w_bin_ok;
            end
            ST_LOAD: w_div_start = 1'b1;
            ST_READ, ST_DIV, ST_FIN: busy = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Peak tracking and clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_peak  <= '0;
            r_last_peak <= '0;
        end else if (w_accept) begin
            unique case (w_act)
                ACT_CLEAR: begin
                    r_run_peak  <= '0;
                    r_last_peak <= '0;
                end
                ACT_WRITE: begin
                    if (w_bin_ok && w_bin_last) begin
                        r_last_peak <= max_cnt(r_last_peak, max_cnt(max_cnt(
                            i_red_count, i_green_count), i_blue_count));
                    end else if (w_bin_ok) begin
                        r_run_peak <= max_cnt(r_run_peak, max_cnt(max_cnt(
                            i_red_count, i_green_count >> 1), i_blue_count));
                    end
                end
                ACT_READ, ACT_NONE: ;
            endcase
        end
    end

    // Read context capture
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_act == ACT_READ)) begin
            r_row  <= i_row;
            r_peak <= (r_run_peak != '0) ? r_run_peak : r_last_peak;
            r_ok   <= w_bin_ok && w_row_ok && ((r_run_peak | r_last_peak) != '0);
        end
    end

    // Scale counts by the last row index, green also halved
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_x_red   <= LAST_X * XW'(w_rdata[3*CNT_W-1:2*CNT_W]);
            r_x_green <= (LAST_X * XW'(w_rdata[2*CNT_W-1:CNT_W])) >> 1;
            r_x_blue  <= LAST_X * XW'(w_rdata[CNT_W-1:0]);
        end
    end

    hopr_ram #(
        .WIDTH (3 * CNT_W),
        .DEPTH (BIN_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_addr),
        .i_wdata ({i_red_count, i_green_count, i_blue_count}),
        .o_rdata (w_rdata)
    );

    hopr_div #(.DW(CNT_W), .QW(RW)) u_div_red (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_div_start),
        .i_dividend (r_x_red), .i_divisor (r_peak),
        .o_quot (w_q_red), .o_sat (w_s_red), .o_done (w_d_red)
    );

    hopr_div #(.DW(CNT_W), .QW(RW)) u_div_green (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_div_start),
        .i_dividend (r_x_green), .i_divisor (r_peak),
        .o_quot (w_q_green), .o_sat (w_s_green), .o_done (w_d_green)
    );

    hopr_div #(.DW(CNT_W), .QW(RW)) u_div_blue (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_div_start),
        .i_dividend (r_x_blue), .i_divisor (r_peak),
        .o_quot (w_q_blue), .o_sat (w_s_blue), .o_done (w_d_blue)
    );

    // Pixel composition: bars, then blue outline over red and green
    always_comb begin
        t_bar b_red, b_green, b_blue;
        b_red       = bar_of(w_q_red, w_s_red, r_row);
        b_green     = bar_of(w_q_green, w_s_green, r_row);
        b_blue      = bar_of(w_q_blue, w_s_blue, r_row);
        n_pix_red   = PIX_NONE;
        n_pix_green = PIX_NONE;
        n_pix_blue  = PIX_NONE;
        if (r_ok) begin
            if (b_red.pos) begin
                n_pix_red = b_red.gt ? PIX_BAR : (b_red.eq ? PIX_TOP : PIX_NONE);
            end
            if (b_green.pos) begin
                n_pix_green = b_green.gt ? PIX_BAR : (b_green.eq ? PIX_TOP : PIX_NONE);
            end
            if (b_blue.pos) begin
                if (b_blue.gt) begin
                    n_pix_blue = ((n_pix_red == PIX_NONE) && (n_pix_green == PIX_NONE))
                                 ? PIX_DIM : PIX_BAR;
                end else if (b_blue.eq) begin
                    n_pix_red   = PIX_DIM;
                    n_pix_green = PIX_DIM;
                    n_pix_blue  = (SW'(r_row) < LAST_ROW) ? PIX_TOP : PIX_NONE;
                end
            end
        end
    end

    // Result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN) begin
            r_pix_red   <= n_pix_red;
            r_pix_green <= n_pix_green;
            r_pix_blue  <= n_pix_blue;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_pixel_red   = r_pix_red;
    assign o_pixel_green = r_pix_green;
    assign o_pixel_blue  = r_pix_blue;

endmodule

// ===== rtl/core/hopr_checker.sv =====
// ---------------------------------------------------------------------------
// hopr_checker
// Port-level checks of the overlay renderer's command sequencing.
// ---------------------------------------------------------------------------
`include "histogram_overlay_pixel_render_unit_assert.svh"

module hopr_checker
    import hopr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_action,
    input logic       o_strobe
);

    logic w_acc;
    assign w_acc = start && !busy;

    // A result beat lasts a single cycle
    `HOPR_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe)

    // A result only ends a busy read
    `HOPR_ASSERT_NOW(a_strobe_after_busy, o_strobe, $past(busy) && !busy)

    // A read holds the unit busy in the next cycle
    `HOPR_ASSERT_NEXT(a_read_busy, w_acc && (i_action == ACT_READ), busy)

    // Clear, write and unused commands finish at once with no result
    `HOPR_ASSERT_NEXT(a_quick_cmd, w_acc && (i_action != ACT_READ), !busy && !o_strobe)

endmodule

bind histogram_overlay_pixel_render_unit hopr_checker u_hopr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_action (i_action),
    .o_strobe (o_strobe)
);
